[hw/rtl/positional_insert_remove_array_macros.svh]
// Assertion macros for the positional insert/remove array.
// Used by the top level only; no other dependencies.
`ifndef POSITIONAL_INSERT_REMOVE_ARRAY_MACROS_SVH
`define POSITIONAL_INSERT_REMOVE_ARRAY_MACROS_SVH

`ifndef SYNTHESIS
// check under reset gating
`define PIRA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pira assertion failed");
// check at every edge, reset included
`define PIRA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pira assertion failed");
`else
`define PIRA_ASSERT(lbl, prop)
`define PIRA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[hw/rtl/pira_pkg.sv]
// Shared types, codes and sizes for the positional insert/remove array.
// No dependencies.
`default_nettype none

package pira_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int POS_W       = 7;
  localparam int LEN_W       = 7;
  localparam int FUNC_W      = 2;
  localparam int STAT_W      = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]             func;
    logic [POS_W-1:0]              pos;
    logic signed [VALUE_WIDTH-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]             status;
    logic [LEN_W-1:0]              length;
    logic signed [VALUE_WIDTH-1:0] read_value;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_WRVAL,
    S_RDWAIT,
    S_DONE
  } state_t;

  // memory request from the sequencer
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wsel_val;  // 1: write item value, 0: write read data
  } mem_req_t;

  // result control from the sequencer
  typedef struct packed {
    logic              fin;
    logic              cap_rd;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  len;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/positional_insert_remove_array.sv]
// Positional insert/remove array: ordered list of up to DEPTH signed values.
// An insert goes from check through the shift and a value write to done, a remove
// through the shift to done, a read through a read wait to done, and a refusal from check
// straight to done; done waits on any output stall. One item at a time: no new item is
// accepted until the result is out of done; the shift moves one entry per cycle through the RAM.
// Reset (rst_n low, synchronous) empties the list; RAM contents are not cleared.
`default_nettype none

`include "positional_insert_remove_array_macros.svh"

module positional_insert_remove_array
  import pira_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  // input items
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  // result items
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic                          in_accept;
  logic                          busy;
  logic                          out_free;
  in_item_t                      item_r;
  logic signed [VALUE_WIDTH-1:0] rdv_r;
  logic                          out_valid_r;
  out_item_t                     out_data_r;
  mem_req_t                      mem;
  res_t                          res;
  logic [VALUE_WIDTH-1:0]        ram_rdata;
  logic [VALUE_WIDTH-1:0]        ram_wdata;

  // Only one item in flight; a pending result does not block acceptance,
  // the sequencer waits in its done state for the output register instead.
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // capture the item for the whole operation
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
  end

  // read value: zero unless a successful read loads it
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rdv_r <= '0;
    end else if (res.cap_rd) begin
      rdv_r <= ram_rdata;
    end
  end

  pira_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_accept(in_accept),
    .item     (item_r),
    .out_free (out_free),
    .busy     (busy),
    .mem      (mem),
    .res      (res)
  );

  // shifting writes back what was just read; the final insert writes the value
  assign ram_wdata = mem.wsel_val ? item_r.value : ram_rdata;

  pira_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem.we),
    .waddr(mem.waddr),
    .wdata(ram_wdata),
    .re   (mem.re),
    .raddr(mem.raddr),
    .rdata(ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fin) begin
      out_data_r.status     <= res.status;
      out_data_r.length     <= res.len;
      out_data_r.read_value <= rdv_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // count stays within capacity
  `PIRA_ASSERT(a_len_cap, res.len <= LEN_W'(DEPTH))
  // an accepted item makes the block busy next cycle
  `PIRA_ASSERT(a_acc_busy, in_accept |=> in_stall)
  // count moves by at most one per cycle
  `PIRA_ASSERT(a_len_step, res.len == $past(res.len) || res.len == $past(res.len) + 1 || res.len + 1 == $past(res.len))
  // full refusal only when the store is full
  `PIRA_ASSERT(a_full_stat, (res.fin && res.status == ST_FULL) |-> res.len == LEN_W'(DEPTH))

endmodule

`default_nettype wire

[hw/rtl/pira_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pira_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pira_ctrl.sv]
// Sequencer: range checks, entry count and the one-entry-per-cycle shift.
// Depends on pira_pkg.
`default_nettype none

module pira_ctrl
  import pira_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_accept,
  input  wire in_item_t item,
  input  wire logic     out_free,
  output logic          busy,
  output mem_req_t      mem,
  output res_t          res
);

  state_t              state_r, state_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic [ADDR_W-1:0]   rd_r, rd_nxt;
  logic [ADDR_W-1:0]   wr_r, wr_nxt;
  logic                pend_r, pend_nxt;
  logic [STAT_W-1:0]   status_r, status_nxt;
  logic                is_ins;

  assign is_ins = (item.func == FN_INSERT);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        unique case (item.func)
          FN_INSERT: begin
            if (item.pos > cnt_r || cnt_r == LEN_W'(DEPTH)) state_nxt = S_DONE;
            else state_nxt = S_SHIFT;
          end
          FN_REMOVE: begin
            if (item.pos >= cnt_r) state_nxt = S_DONE;
            else state_nxt = S_SHIFT;
          end
          FN_READ: begin
            if (item.pos >= cnt_r) state_nxt = S_DONE;
            else state_nxt = S_RDWAIT;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SHIFT: begin
        if (rem_r == '0 && !pend_r) state_nxt = is_ins ? S_WRVAL : S_DONE;
      end
      S_WRVAL:  state_nxt = S_DONE;
      S_RDWAIT: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath registers
  always_comb begin
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    rd_nxt       = rd_r;
    wr_nxt       = wr_r;
    pend_nxt     = 1'b0;
    status_nxt   = status_r;
    mem          = '0;
    unique case (state_r)
      S_CHECK: begin
        status_nxt = ST_RANGE;
        unique case (item.func)
          FN_INSERT: begin
            if (item.pos > cnt_r) begin
              status_nxt = ST_RANGE;
            end else if (cnt_r == LEN_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              // move entries pos..cnt-1 up, top first
              status_nxt = ST_DONE;
              rem_nxt    = cnt_r - item.pos;
              rd_nxt     = cnt_r[ADDR_W-1:0] - ADDR_W'(1);
              wr_nxt     = cnt_r[ADDR_W-1:0];
            end
          end
          FN_REMOVE: begin
            if (item.pos < cnt_r) begin
              // move entries pos+1..cnt-1 down, bottom first
              status_nxt = ST_DONE;
              rem_nxt    = cnt_r - item.pos - LEN_W'(1);
              rd_nxt     = item.pos[ADDR_W-1:0] + ADDR_W'(1);
              wr_nxt     = item.pos[ADDR_W-1:0];
            end
          end
          FN_READ: begin
            if (item.pos < cnt_r) begin
              status_nxt = ST_DONE;
              mem.re     = 1'b1;
              mem.raddr  = item.pos[ADDR_W-1:0];
            end
          end
          default: status_nxt = ST_RANGE;
        endcase
      end
      S_SHIFT: begin
        // read one ahead, write the word read last cycle
        if (rem_r != '0) begin
          mem.re    = 1'b1;
          mem.raddr = rd_r;
          rd_nxt    = is_ins ? rd_r - ADDR_W'(1) : rd_r + ADDR_W'(1);
          rem_nxt   = rem_r - LEN_W'(1);
          pend_nxt  = 1'b1;
        end
        if (pend_r) begin
          mem.we    = 1'b1;
          mem.waddr = wr_r;
          wr_nxt    = is_ins ? wr_r - ADDR_W'(1) : wr_r + ADDR_W'(1);
        end
        if (rem_r == '0 && !pend_r && !is_ins) cnt_nxt = cnt_r - LEN_W'(1);
      end
      S_WRVAL: begin
        mem.we       = 1'b1;
        mem.waddr    = item.pos[ADDR_W-1:0];
        mem.wsel_val = 1'b1;
        cnt_nxt      = cnt_r + LEN_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign res.fin    = (state_r == S_DONE) && out_free;
  assign res.cap_rd = (state_r == S_RDWAIT);
  assign res.status = status_r;
  assign res.len    = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    rd_r     <= rd_nxt;
    wr_r     <= wr_nxt;
    status_r <= status_nxt;
  end

endmodule

`default_nettype wire
